### sv/lph_pkg.sv
package lph_pkg;

  localparam int KEY_W = 32;
  localparam int HASH_W = 32;
  localparam int VALUE_W = 64;
  localparam int LIMIT_W = 7;
  localparam int ADDR_W = 3;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_LIVE = 2'd1;
  localparam logic [1:0] SLOT_TOMB = 2'd2;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  localparam logic REG_LOAD_LIMIT = 1'b0;
  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = 7'd48;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [KEY_W-1:0]   key_id;
    logic [HASH_W-1:0]  key_hash;
    logic [VALUE_W-1:0] value_in;
    logic               const_flag;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               was_new;
    logic [VALUE_W-1:0] value_out;
    logic               value_const;
  } out_t;

  typedef struct packed {
    logic       st_we;
    logic [1:0] st;
    logic       kv_we;
  } slot_wr_t;

endpackage

### sv/lph_store.sv
module lph_store #(
  parameter int DEPTH = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic                       clk,
  input  logic [$clog2(DEPTH)-1:0]   addr,
  input  lph_pkg::slot_wr_t          wr,
  input  logic [lph_pkg::KEY_W-1:0]  key_wdata,
  input  logic [VALUE_BITS-1:0]      value_wdata,
  input  logic                       const_wdata,
  output logic [1:0]                 rd_status,
  output logic [lph_pkg::KEY_W-1:0]  rd_key,
  output logic [VALUE_BITS-1:0]      rd_value,
  output logic                       rd_const
);

  logic [1:0]                status_mem [DEPTH];
  logic [lph_pkg::KEY_W-1:0] key_mem [DEPTH];
  logic [VALUE_BITS:0]       data_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.st_we) begin
      status_mem[addr] <= wr.st;
    end
    rd_status <= status_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (wr.kv_we) begin
      key_mem[addr] <= key_wdata;
      data_mem[addr] <= {const_wdata, value_wdata};
    end
    rd_key <= key_mem[addr];
    {rd_const, rd_value} <= data_mem[addr];
  end

endmodule

### sv/linear_probe_hash_table.sv
// channel   dir  handshake            payload
// in        in   in_valid/in_ready    in_data  (lph_pkg::in_t)
// out       out  out_valid/out_ready  out_data (lph_pkg::out_t)
// cfg       in   psel/penable/pwrite  paddr, pwdata, prdata, pready
//
// Lookup/insert/remove: accept in S_IDLE, hash reduction in S_MOD when TABLE_SIZE
// is not a power of two (none otherwise), S_READ then S_CHECK per probed slot, then S_ACT.
// Clear: S_CLEAR sweeps every slot, then S_ACT. The slot memory has one port.
// After reset S_INIT sweeps every slot to empty; in_ready stays low meanwhile.
// A result held by out_ready stalls only the finish state S_ACT; the next beat is taken.
module linear_probe_hash_table #(
  parameter int TABLE_SIZE = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  lph_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lph_pkg::out_t               out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lph_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int UW = $clog2(TABLE_SIZE + 1);
  localparam int CMPW = ((UW > lph_pkg::LIMIT_W) ? UW : lph_pkg::LIMIT_W) + 1;
  localparam bit POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

  // hash mod TABLE_SIZE by reciprocal multiply, exact for every 32-bit hash
  localparam int HALF_W = lph_pkg::HASH_W / 2;
  localparam int RECIP_SH = lph_pkg::HASH_W + IW;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RECIP_SH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
  localparam logic [32:0] RECIP = RECIP_FULL[32:0];
  localparam int MUL_W = HALF_W + 33;
  localparam int PROD_W = lph_pkg::HASH_W + 33;

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_READ  = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_CLEAR = 7'b0100000,
    S_ACT   = 7'b1000000
  } state_t;

  state_t                          state;
  logic [IW-1:0]                   idx;
  logic [IW-1:0]                   idx_next;
  logic [UW-1:0]                   cnt;
  logic [1:0]                      mod_step;
  logic [UW-1:0]                   used_count;
  logic [lph_pkg::LIMIT_W-1:0]     load_limit;

  logic [1:0]                      op;
  logic [lph_pkg::KEY_W-1:0]       key;
  logic [lph_pkg::HASH_W-1:0]      hash;
  logic [VALUE_BITS-1:0]           val;
  logic                            cflag;

  logic                            match;
  logic                            found_empty;
  logic                            tomb_valid;
  logic [IW-1:0]                   tomb_idx;
  logic [VALUE_BITS-1:0]           res_value;
  logic                            res_const;

  logic [HALF_W-1:0]               mul_a;
  logic [MUL_W-1:0]                mul_out;
  logic [PROD_W-1:0]               prod;
  logic [IW-1:0]                   q_lo;
  logic [IW-1:0]                   mod_rem;
  logic [IW-1:0]                   land;
  logic                            land_valid;
  logic                            land_empty;
  logic                            fresh_ok;
  logic                            ins_ok;
  logic                            out_free;
  logic                            last_probe;
  lph_pkg::out_t                   res;

  lph_pkg::slot_wr_t               wr;
  logic [IW-1:0]                   mem_addr;
  logic [1:0]                      rd_status;
  logic [lph_pkg::KEY_W-1:0]       rd_key;
  logic [VALUE_BITS-1:0]           rd_value;
  logic                            rd_const;

  assign pready = 1'b1;
  assign prdata = (paddr[lph_pkg::ADDR_W-1:2] == lph_pkg::REG_LOAD_LIMIT) ?
                  32'(load_limit) : 32'd0;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign idx_next = (idx == IW'(TABLE_SIZE - 1)) ? '0 : idx + 1'b1;
  assign last_probe = (cnt == UW'(TABLE_SIZE - 1));

  assign mul_a = mod_step[0] ? hash[lph_pkg::HASH_W-1:HALF_W] : hash[HALF_W-1:0];
  assign mul_out = MUL_W'(mul_a) * MUL_W'(RECIP);
  assign q_lo = prod[RECIP_SH +: IW];
  assign mod_rem = hash[IW-1:0] - IW'(q_lo * IW'(TABLE_SIZE));

  assign land = (match || !tomb_valid) ? idx : tomb_idx;
  assign land_valid = match || tomb_valid || found_empty;
  assign land_empty = found_empty && !tomb_valid && !match;
  assign fresh_ok = (CMPW'(used_count) + 1'b1) <= CMPW'(load_limit);
  assign ins_ok = match || (land_valid && (!land_empty || fresh_ok));

  assign mem_addr = (state == S_ACT) ? land : idx;

  always_comb begin
    wr = '0;
    unique case (state)
      S_INIT, S_CLEAR: begin
        wr.st_we = 1'b1;
        wr.st = lph_pkg::SLOT_EMPTY;
      end
      S_ACT: begin
        if (out_free) begin
          if (op == lph_pkg::OP_REMOVE && match) begin
            wr.st_we = 1'b1;
            wr.st = lph_pkg::SLOT_TOMB;
          end else if (op == lph_pkg::OP_INSERT && ins_ok) begin
            wr.st_we = 1'b1;
            wr.st = lph_pkg::SLOT_LIVE;
            wr.kv_we = 1'b1;
          end
        end
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  always_comb begin
    res = '0;
    if (state == S_ACT) begin
      unique case (op)
        lph_pkg::OP_LOOKUP: begin
          if (match) begin
            res.value_out = lph_pkg::VALUE_W'(res_value);
            res.value_const = res_const;
          end else begin
            res.status = lph_pkg::STAT_NOT_FOUND;
          end
        end
        lph_pkg::OP_REMOVE: begin
          if (!match) begin
            res.status = lph_pkg::STAT_NOT_FOUND;
          end
        end
        lph_pkg::OP_INSERT: begin
          if (ins_ok) begin
            res.was_new = !match;
          end else begin
            res.status = lph_pkg::STAT_FULL;
          end
        end
        lph_pkg::OP_CLEAR: begin
          res.status = lph_pkg::STAT_DONE;
        end
      endcase
    end
  end

  lph_store #(
    .DEPTH(TABLE_SIZE),
    .VALUE_BITS(VALUE_BITS)
  ) u_store (
    .clk(clk),
    .addr(mem_addr),
    .wr(wr),
    .key_wdata(key),
    .value_wdata(val),
    .const_wdata(cflag),
    .rd_status(rd_status),
    .rd_key(rd_key),
    .rd_value(rd_value),
    .rd_const(rd_const)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      load_limit <= lph_pkg::LOAD_LIMIT_RESET;
    end else if (psel && penable && pwrite &&
                 paddr[lph_pkg::ADDR_W-1:2] == lph_pkg::REG_LOAD_LIMIT) begin
      load_limit <= pwdata[lph_pkg::LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      idx <= '0;
      cnt <= '0;
      mod_step <= '0;
      used_count <= '0;
      match <= 1'b0;
      found_empty <= 1'b0;
      tomb_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_ACT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          idx <= idx_next;
          if (idx == IW'(TABLE_SIZE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op <= in_data.opcode;
            key <= in_data.key_id;
            hash <= in_data.key_hash;
            val <= VALUE_BITS'(in_data.value_in);
            cflag <= in_data.const_flag;
            cnt <= '0;
            mod_step <= '0;
            match <= 1'b0;
            found_empty <= 1'b0;
            tomb_valid <= 1'b0;
            if (in_data.opcode == lph_pkg::OP_CLEAR) begin
              idx <= '0;
              state <= S_CLEAR;
            end else if (POW2) begin
              idx <= in_data.key_hash[IW-1:0];
              state <= S_READ;
            end else begin
              idx <= '0;
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          mod_step <= mod_step + 1'b1;
          unique case (mod_step)
            2'd0: begin
              prod <= PROD_W'(mul_out);
            end
            2'd1: begin
              prod <= prod + {mul_out, {HALF_W{1'b0}}};
            end
            default: begin
              idx <= mod_rem;
              state <= S_READ;
            end
          endcase
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (rd_status == lph_pkg::SLOT_EMPTY) begin
            found_empty <= 1'b1;
            state <= S_ACT;
          end else if (rd_status == lph_pkg::SLOT_LIVE && rd_key == key) begin
            match <= 1'b1;
            res_value <= rd_value;
            res_const <= rd_const;
            state <= S_ACT;
          end else begin
            if (rd_status != lph_pkg::SLOT_LIVE && !tomb_valid) begin
              tomb_valid <= 1'b1;
              tomb_idx <= idx;
            end
            if (last_probe) begin
              state <= S_ACT;
            end else begin
              idx <= idx_next;
              cnt <= cnt + 1'b1;
              state <= S_READ;
            end
          end
        end
        S_CLEAR: begin
          idx <= idx_next;
          if (idx == IW'(TABLE_SIZE - 1)) begin
            used_count <= '0;
            state <= S_ACT;
          end
        end
        S_ACT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data <= res;
            if (op == lph_pkg::OP_INSERT && ins_ok && land_empty) begin
              used_count <= used_count + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

endmodule
